FILE: rtl/rdrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdrm_pkg: shared definitions for the dose-rate meter
// Default sizes, register indexes and the stream word layouts.
// ----------------------------------------------------------------------------
package rdrm_pkg;

	localparam int HISTORY_DEPTH_DEF = 200;
	localparam int COUNT_WIDTH_DEF   = 16;

	localparam int ADDR_W  = 64;
	localparam int ALPHA_W = 16;
	localparam int RATE_W  = 24;
	localparam int DOSE_W  = 36;
	localparam int WCNT_W  = 16;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd13576;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SENSOR_ADDRESS  = 2'd0,
		CFG_ALPHA_Q8        = 2'd1,
		CFG_END_DEVICE_MODE = 2'd2
	} cfg_reg_t;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	localparam int IN_TDATA_W = 72;
	localparam int IN_PULSE_BIT = 64;
	localparam int IN_NOISE_BIT = 65;

	localparam int OUT_TDATA_W   = 96;
	localparam int OUT_RATE_LSB  = 0;
	localparam int OUT_DOSE_LSB  = OUT_RATE_LSB + RATE_W;
	localparam int OUT_PULSE_LSB = OUT_DOSE_LSB + DOSE_W;
	localparam int OUT_NOISE_LSB = OUT_PULSE_LSB + WCNT_W;
	localparam int OUT_ACC_BIT   = OUT_NOISE_LSB + WCNT_W;
	localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_ACC_BIT - 1;

endpackage

FILE: rtl/rdrm_sdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdrm_sdiv: bit-serial restoring divider
// Shifts one dividend bit per cycle into a narrow remainder and saturates the
// quotient to all ones when it does not fit the output width.
// ----------------------------------------------------------------------------
module rdrm_sdiv #(
	parameter int NUM_W = 52,
	parameter int DEN_W = 24,
	parameter int OUT_W = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             busy,
	output logic [OUT_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_sh_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [OUT_W-1:0] quo_q;
	logic             ovf_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;
	logic [DEN_W-1:0] rem_nxt;

	assign trial   = {rem_q, num_sh_q[NUM_W-1]};
	assign ge      = trial >= {1'b0, den_q};
	assign diff    = trial - {1'b0, den_q};
	assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

	assign busy = cnt_q != '0;
	assign quot = ovf_q ? '1 : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_sh_q <= numer;
			den_q    <= denom;
			rem_q    <= '0;
			quo_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (busy) begin
			num_sh_q <= {num_sh_q[NUM_W-2:0], 1'b0};
			rem_q    <= rem_nxt;
			if (OUT_W > 1) begin
				quo_q <= OUT_W'({quo_q, ge});
			end else begin
				quo_q <= OUT_W'(ge);
			end
			ovf_q    <= ovf_q | quo_q[OUT_W-1];
		end
	end

endmodule

FILE: rtl/radiation_dose_rate_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radiation_dose_rate_meter: sliding-window counts per minute and dose rate
// Counts sensor pulses per six-second window, keeps a ring of window counts
// and reports cpm (Q4) and uSv/h (Q16) on every window tick.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                         Word
//  s_axis    in         tvalid tready tdata[71:0] tuser  report or tick
//  m_axis    out        tvalid tready tdata[95:0]        window result
//  cfg       in         valid ready index[1:0] data[63:0] register write
//
// A report leaves the input open. A tick goes through the update state (skipped
// for a window skipped for noise), start, divide and output states before
// m_axis_tvalid rises, and the input reopens in the same cycle. The bit-serial
// dose divider, the longer of the two, sets how long the divide state lasts.
// The ring is never cleared: a slot reads as zero until the window count
// shows that the ring has wrapped, so reset needs no clearing pass.
// Reports are taken while a result waits on m_axis; a later tick finishes
// its work and then holds until the output register is free.
module radiation_dose_rate_meter #(
	parameter int HISTORY_DEPTH = rdrm_pkg::HISTORY_DEPTH_DEF,
	parameter int COUNT_WIDTH   = rdrm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [63:0] source_address, [64] pulse_level, [65] noise_level
	input  logic [rdrm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [0] kind
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [23:0] rate_cpm_q4, [59:24] dose_usv_q16, [75:60] window_pulses,
	// [91:76] window_noise, [92] window_accepted
	output logic [rdrm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rdrm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rdrm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int SLOT_W     = $clog2(HISTORY_DEPTH);
	localparam int WIN_W      = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W      = COUNT_WIDTH + $clog2(HISTORY_DEPTH);
	localparam int NUM_W      = SUM_W + 4;
	localparam int RATE_NUM_W = NUM_W + 4;
	localparam int DOSE_NUM_W = NUM_W + 24;
	localparam int DOSE_DEN_W = WIN_W + rdrm_pkg::ALPHA_W;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_UPDATE = 5'b00010,
		ST_START  = 5'b00100,
		ST_DIVIDE = 5'b01000,
		ST_OUTPUT = 5'b10000
	} state_t;

	state_t state_q;

	logic [rdrm_pkg::ADDR_W-1:0]  sensor_addr_q;
	logic [rdrm_pkg::ALPHA_W-1:0] alpha_q;
	logic                         edm_q;

	logic [COUNT_WIDTH-1:0] pulse_cnt_q;
	logic [COUNT_WIDTH-1:0] noise_cnt_q;
	logic                   last_level_q;
	logic [COUNT_WIDTH-1:0] pulse_snap_q;
	logic [COUNT_WIDTH-1:0] noise_snap_q;
	logic                   acc_q;

	logic [COUNT_WIDTH-1:0] hist_mem [HISTORY_DEPTH];
	logic [COUNT_WIDTH-1:0] hist_rd_q;
	logic                   hist_rd_vld_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [SLOT_W-1:0]      slot_nxt;
	logic [SUM_W-1:0]       sum_q;
	logic [WIN_W-1:0]       windows_q;

	logic                   m_valid_q;
	logic [rdrm_pkg::OUT_TDATA_W-1:0] m_data_q;

	logic in_acc;
	logic report_acc;
	logic tick_acc;
	logic addr_match;
	logic level;
	logic noise;
	logic [1:0] pulse_inc;
	logic [COUNT_WIDTH:0] pulse_add;
	logic [COUNT_WIDTH:0] noise_add;
	logic tick_ok;

	logic [NUM_W-1:0]      num_c;
	logic [DOSE_DEN_W-1:0] dose_den_c;
	logic                  div_start;
	logic                  rate_busy;
	logic                  dose_busy;
	logic [rdrm_pkg::RATE_W-1:0] rate_quot;
	logic [rdrm_pkg::DOSE_W-1:0] dose_quot;
	logic [rdrm_pkg::RATE_W-1:0] rate_out;
	logic [rdrm_pkg::DOSE_W-1:0] dose_out;
	logic out_free;

	assign s_axis_tready = state_q == ST_IDLE;
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign report_acc    = in_acc && s_axis_tuser[0] == rdrm_pkg::KIND_REPORT;
	assign tick_acc      = in_acc && s_axis_tuser[0] == rdrm_pkg::KIND_TICK;
	assign tick_ok       = noise_cnt_q == '0;

	assign addr_match = s_axis_tdata[rdrm_pkg::ADDR_W-1:0] == sensor_addr_q;
	assign level      = s_axis_tdata[rdrm_pkg::IN_PULSE_BIT];
	assign noise      = s_axis_tdata[rdrm_pkg::IN_NOISE_BIT];

	always_comb begin
		if (edm_q) begin
			pulse_inc = (level == last_level_q) ? 2'd2 : 2'd1;
		end else begin
			pulse_inc = level ? 2'd0 : 2'd1;
		end
		pulse_add = {1'b0, pulse_cnt_q} + (COUNT_WIDTH + 1)'(pulse_inc);
		noise_add = {1'b0, noise_cnt_q} + (COUNT_WIDTH + 1)'(noise);
	end

	assign slot_nxt = (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_addr_q <= '0;
			alpha_q       <= rdrm_pkg::ALPHA_RESET;
			edm_q         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rdrm_pkg::CFG_SENSOR_ADDRESS: begin
					sensor_addr_q <= cfg_data[rdrm_pkg::ADDR_W-1:0];
				end
				rdrm_pkg::CFG_ALPHA_Q8: begin
					alpha_q <= cfg_data[rdrm_pkg::ALPHA_W-1:0];
				end
				rdrm_pkg::CFG_END_DEVICE_MODE: begin
					edm_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_cnt_q  <= '0;
			noise_cnt_q  <= '0;
			last_level_q <= 1'b0;
		end else if (report_acc && addr_match) begin
			pulse_cnt_q <= pulse_add[COUNT_WIDTH] ? '1 : pulse_add[COUNT_WIDTH-1:0];
			noise_cnt_q <= noise_add[COUNT_WIDTH] ? '1 : noise_add[COUNT_WIDTH-1:0];
			if (edm_q) begin
				last_level_q <= level;
			end
		end else if (tick_acc) begin
			pulse_cnt_q <= '0;
			noise_cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			pulse_snap_q  <= pulse_cnt_q;
			noise_snap_q  <= noise_cnt_q;
			acc_q         <= tick_ok;
			hist_rd_q     <= hist_mem[slot_nxt];
			hist_rd_vld_q <= windows_q == WIN_W'(HISTORY_DEPTH);
		end
		if (state_q == ST_UPDATE) begin
			hist_mem[slot_q] <= pulse_snap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			slot_q     <= '0;
			sum_q      <= '0;
			windows_q  <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_acc) begin
						if (tick_ok) begin
							slot_q  <= slot_nxt;
							state_q <= ST_UPDATE;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_UPDATE: begin
					sum_q <= sum_q - (hist_rd_vld_q ? SUM_W'(hist_rd_q) : '0)
						+ SUM_W'(pulse_snap_q);
					if (windows_q != WIN_W'(HISTORY_DEPTH)) begin
						windows_q <= windows_q + 1'b1;
					end
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (!rate_busy && !dose_busy) begin
						state_q <= ST_OUTPUT;
					end
				end
				ST_OUTPUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign num_c      = (NUM_W'(sum_q) << 3) + (NUM_W'(sum_q) << 1);
	assign dose_den_c = DOSE_DEN_W'(windows_q) * DOSE_DEN_W'(alpha_q);
	assign div_start  = state_q == ST_START;

	rdrm_sdiv #(
		.NUM_W (RATE_NUM_W),
		.DEN_W (WIN_W),
		.OUT_W (rdrm_pkg::RATE_W)
	) u_rate_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  ({num_c, 4'b0}),
		.denom  (windows_q),
		.busy   (rate_busy),
		.quot   (rate_quot)
	);

	rdrm_sdiv #(
		.NUM_W (DOSE_NUM_W),
		.DEN_W (DOSE_DEN_W),
		.OUT_W (rdrm_pkg::DOSE_W)
	) u_dose_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  ({num_c, 24'b0}),
		.denom  (dose_den_c),
		.busy   (dose_busy),
		.quot   (dose_quot)
	);

	assign out_free = !m_valid_q || m_axis_tready;
	assign rate_out = (windows_q == '0) ? '0 : rate_quot;
	assign dose_out = (windows_q == '0) ? '0 : dose_quot;

	always_ff @(posedge clk) begin
		if (state_q == ST_OUTPUT && out_free) begin
			m_data_q <= {
				{rdrm_pkg::OUT_PAD_W{1'b0}},
				acc_q,
				rdrm_pkg::WCNT_W'(noise_snap_q),
				rdrm_pkg::WCNT_W'(pulse_snap_q),
				dose_out,
				rate_out
			};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

FILE: rtl/rdrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdrm_checker: port-level checks for the dose-rate meter
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module rdrm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [0:0]                       s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [rdrm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_accept_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[rdrm_pkg::OUT_ACC_BIT] ==
			(m_axis_tdata[rdrm_pkg::OUT_ACC_BIT-1:rdrm_pkg::OUT_NOISE_LSB] == '0))
		else $error("window accepted flag disagrees with noise count");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == rdrm_pkg::KIND_TICK
			|=> !s_axis_tready)
		else $error("input still open after a tick");

	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without tick processing");

endmodule

bind radiation_dose_rate_meter rdrm_checker u_rdrm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

FILE: test/radiation_dose_rate_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radiation_dose_rate_meter_tb: self-checking bench for the dose-rate meter
// Sensor reports and window ticks stream in while a local model of the
// window counts, the history ring and the cpm and dose arithmetic predicts
// every window result. Each result word is compared field by field. Phases
// vary the registers and the idling of both stream sides, and they include
// a zero and a tiny alpha, a long burst of reports in one window, and a long
// output stall.
// ----------------------------------------------------------------------------
module radiation_dose_rate_meter_tb;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 70;
	localparam int SECS_MAX = rdrm_pkg::HISTORY_DEPTH_DEF * 6;
	localparam longint unsigned RATE_MAX = (64'd1 << rdrm_pkg::RATE_W) - 1;
	localparam longint unsigned DOSE_MAX = (64'd1 << rdrm_pkg::DOSE_W) - 1;

	typedef struct {
		logic        kind;
		logic [63:0] addr;
		logic        pulse;
		logic        noise;
	} sensor_word_t;

	typedef struct {
		logic [rdrm_pkg::RATE_W-1:0] rate;
		logic [rdrm_pkg::DOSE_W-1:0] dose;
		logic [rdrm_pkg::WCNT_W-1:0] pulses;
		logic [rdrm_pkg::WCNT_W-1:0] noise;
		logic                        accepted;
	} window_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	// [63:0] source_address, [64] pulse_level, [65] noise_level
	logic [rdrm_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// [0] kind
	logic [0:0]                       s_axis_tuser = '0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	// [23:0] rate_cpm_q4, [59:24] dose_usv_q16, [75:60] window_pulses,
	// [91:76] window_noise, [92] window_accepted
	logic [rdrm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [rdrm_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [rdrm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	sensor_word_t   feed_q[$];
	window_result_t result_q[$];
	sensor_word_t   offer_word;
	bit             word_out = 0;
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             stall_request = 0;
	int             stall_left = 0;
	int             fail_count = 0;
	int             quiet_cycles = 0;

	// Model of the meter.
	logic [63:0]                  meter_addr;
	logic [rdrm_pkg::ALPHA_W-1:0] meter_alpha;
	logic                         meter_end_dev;
	logic [rdrm_pkg::WCNT_W-1:0]  meter_ring[rdrm_pkg::HISTORY_DEPTH_DEF];
	longint unsigned              meter_sum;
	int                           meter_slot;
	int                           meter_secs;
	logic [rdrm_pkg::WCNT_W-1:0]  meter_pulses;
	logic [rdrm_pkg::WCNT_W-1:0]  meter_noise;
	logic                         meter_last;

	radiation_dose_rate_meter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [rdrm_pkg::WCNT_W-1:0] sat_bump(
			logic [rdrm_pkg::WCNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void predict_word(sensor_word_t w);
		window_result_t r;
		longint unsigned windows;
		longint unsigned num;
		longint unsigned q;
		if (w.kind == rdrm_pkg::KIND_REPORT) begin
			if (w.addr == meter_addr) begin
				if (meter_end_dev) begin
					meter_pulses = sat_bump(meter_pulses);
					if (w.pulse == meter_last)
						meter_pulses = sat_bump(meter_pulses);
					meter_last = w.pulse;
				end else if (!w.pulse) begin
					meter_pulses = sat_bump(meter_pulses);
				end
				if (w.noise)
					meter_noise = sat_bump(meter_noise);
			end
		end else begin
			r.accepted = (meter_noise == 0);
			r.rate = '0;
			r.dose = '0;
			if (r.accepted) begin
				meter_slot = (meter_slot == rdrm_pkg::HISTORY_DEPTH_DEF - 1) ? 0 :
					meter_slot + 1;
				meter_sum = meter_sum - meter_ring[meter_slot] + meter_pulses;
				meter_ring[meter_slot] = meter_pulses;
				meter_secs = (meter_secs >= SECS_MAX) ? SECS_MAX : meter_secs + 6;
			end
			if (meter_secs != 0) begin
				windows = longint'(meter_secs / 6);
				num = meter_sum * 10;
				q = num * 16 / windows;
				r.rate = (q > RATE_MAX) ? '1 : q[rdrm_pkg::RATE_W-1:0];
				if (meter_alpha == 0) begin
					r.dose = '1;
				end else begin
					q = (num << 24) / (windows * meter_alpha);
					r.dose = (q > DOSE_MAX) ? '1 : q[rdrm_pkg::DOSE_W-1:0];
				end
			end
			r.pulses = meter_pulses;
			r.noise = meter_noise;
			result_q.push_back(r);
			meter_pulses = '0;
			meter_noise = '0;
		end
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
		fail_count++;
		if (fail_count <= 60)
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
	endtask

	// Driver: offers queued words, keeps tvalid up until the word is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_word(offer_word);
				word_out = 0;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					offer_word = feed_q.pop_front();
					word_out = 1;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {{(rdrm_pkg::IN_TDATA_W - 66){1'b0}}, offer_word.noise,
						offer_word.pulse, offer_word.addr};
					s_axis_tuser <= offer_word.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks result words and drives the output back-pressure.
	always @(posedge clk) begin
		window_result_t got;
		window_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.rate = m_axis_tdata[rdrm_pkg::OUT_RATE_LSB +: rdrm_pkg::RATE_W];
				got.dose = m_axis_tdata[rdrm_pkg::OUT_DOSE_LSB +: rdrm_pkg::DOSE_W];
				got.pulses = m_axis_tdata[rdrm_pkg::OUT_PULSE_LSB +: rdrm_pkg::WCNT_W];
				got.noise = m_axis_tdata[rdrm_pkg::OUT_NOISE_LSB +: rdrm_pkg::WCNT_W];
				got.accepted = m_axis_tdata[rdrm_pkg::OUT_ACC_BIT];
				if (result_q.size() == 0) begin
					flag_mismatch("result word with none expected", 64'(got.rate), 64'd0);
				end else begin
					want = result_q.pop_front();
					if (got.rate !== want.rate)
						flag_mismatch("rate_cpm_q4", 64'(got.rate), 64'(want.rate));
					if (got.dose !== want.dose)
						flag_mismatch("dose_usv_q16", 64'(got.dose), 64'(want.dose));
					if (got.pulses !== want.pulses)
						flag_mismatch("window_pulses", 64'(got.pulses), 64'(want.pulses));
					if (got.noise !== want.noise)
						flag_mismatch("window_noise", 64'(got.noise), 64'(want.noise));
					if (got.accepted !== want.accepted)
						flag_mismatch("window_accepted", 64'(got.accepted),
							64'(want.accepted));
				end
			end
			if (stall_request > 0) begin
				stall_left = stall_request;
				stall_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic write_reg(rdrm_pkg::cfg_reg_t idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rdrm_pkg::CFG_SENSOR_ADDRESS: meter_addr = val;
			rdrm_pkg::CFG_ALPHA_Q8: meter_alpha = val[rdrm_pkg::ALPHA_W-1:0];
			rdrm_pkg::CFG_END_DEVICE_MODE: meter_end_dev = val[0];
			default: ;
		endcase
	endtask

	// Unused upper data bits carry random junk on the narrow registers.
	task automatic configure(logic [63:0] addr, logic [rdrm_pkg::ALPHA_W-1:0] alpha,
			logic mode);
		write_reg(rdrm_pkg::CFG_SENSOR_ADDRESS, addr);
		write_reg(rdrm_pkg::CFG_ALPHA_Q8, {$urandom, 16'($urandom_range(65535)), alpha});
		write_reg(rdrm_pkg::CFG_END_DEVICE_MODE, {$urandom, 31'($urandom), mode});
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (feed_q.size() != 0 || word_out || result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_report(logic [63:0] addr, logic pulse, logic noise);
		sensor_word_t w;
		w.kind = rdrm_pkg::KIND_REPORT;
		w.addr = addr;
		w.pulse = pulse;
		w.noise = noise;
		feed_q.push_back(w);
	endfunction

	// Tick words carry random junk in the fields the block ignores.
	function automatic void push_tick();
		sensor_word_t w;
		w.kind = rdrm_pkg::KIND_TICK;
		w.addr = {$urandom, $urandom};
		w.pulse = 1'($urandom_range(1));
		w.noise = 1'($urandom_range(1));
		feed_q.push_back(w);
	endfunction

	function automatic void set_idling(int mode);
		case (mode)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 59; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 59; end
			default: begin send_idle_pct = 35; recv_stall_pct = 35; end
		endcase
	endfunction

	initial begin
		logic [63:0] addr;
		logic [63:0] other;
		logic [rdrm_pkg::ALPHA_W-1:0] alpha;
		int count;
		int reports;
		bit noisy;

		meter_addr = '0;
		meter_alpha = rdrm_pkg::ALPHA_RESET;
		meter_end_dev = 1'b0;
		foreach (meter_ring[i])
			meter_ring[i] = '0;
		meter_sum = 0;
		meter_slot = 0;
		meter_secs = 0;
		meter_pulses = '0;
		meter_noise = '0;
		meter_last = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a noisy first window leaves no elapsed time.
		push_report(64'd0, 1'b0, 1'b1);
		push_tick();
		push_report(64'd0, 1'b0, 1'b0);
		push_report(64'd0, 1'b1, 1'b0);
		push_report('1, 1'b0, 1'b1);
		push_report(64'd1, 1'b0, 1'b0);
		push_tick();
		push_tick();
		wait_idle();

		// End-device mode with repeated levels counted as lost words.
		configure('1, 16'hFFFF, 1'b1);
		push_report('1, 1'b0, 1'b0);
		push_report('1, 1'b1, 1'b0);
		push_report('1, 1'b1, 1'b0);
		push_report('1, 1'b0, 1'b1);
		push_tick();
		push_report(64'd0, 1'b0, 1'b0);
		push_tick();
		wait_idle();

		// Zero alpha saturates the dose, then a tiny alpha gives a large dose.
		configure(64'h8000_0000_0000_0001, 16'd0, 1'b0);
		push_report(64'h8000_0000_0000_0001, 1'b0, 1'b0);
		push_tick();
		wait_idle();
		configure(64'h8000_0000_0000_0001, 16'd1, 1'b0);
		repeat (3) push_report(64'h8000_0000_0000_0001, 1'b0, 1'b0);
		push_tick();
		wait_idle();

		// A long burst of end-device reports builds a large window count.
		addr = {$urandom, $urandom};
		configure(addr, 16'd256, 1'b1);
		repeat (40) push_report(addr, 1'b1, 1'b0);
		push_tick();
		repeat (30) push_report(addr, 1'b1, 1'b1);
		push_tick();
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			set_idling(ph % 4);
			case ($urandom_range(3))
				0: addr = '0;
				1: addr = '1;
				default: addr = {$urandom, $urandom};
			endcase
			case ($urandom_range(9))
				0: alpha = 16'd256;
				1: alpha = 16'hFFFF;
				2: alpha = 16'($urandom_range(255));
				default: alpha = 16'($urandom_range(65535, 256));
			endcase
			configure(addr, alpha, 1'($urandom_range(1)));
			count = 0;
			while (count < 125) begin
				reports = ($urandom_range(7) == 0) ? $urandom_range(12, 4) : $urandom_range(3);
				noisy = ($urandom_range(5) == 0);
				for (int i = 0; i < reports; i++) begin
					other = addr;
					case ($urandom_range(11))
						0: other = {$urandom, $urandom};
						1: other = addr ^ (64'd1 << $urandom_range(63));
						default: ;
					endcase
					push_report(other, 1'($urandom_range(1)),
						noisy ? 1'($urandom_range(1)) : 1'b0);
				end
				push_tick();
				count += reports + 1;
			end
			if (ph == 0)
				stall_request = 400;
			wait_idle();
		end

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
